>>> src/stok_pkg.sv
// Shared types, constants and character helpers for the script tokenizer.
`default_nettype none

package stok_pkg;

    // Width of the byte offset and run counters
    localparam int OFFSET_BITS = 16;
    localparam int FIELD_BITS  = 16;
    localparam int WIDE_BITS   = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    // Token queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_E   = 8'h65;
    localparam logic [7:0] CH_LC_I   = 8'h69;
    localparam logic [7:0] CH_LC_L   = 8'h6C;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_P   = 8'h70;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;

    // Keyword tracker codes
    localparam logic [3:0] KW_NONE = 4'd0;
    localparam logic [3:0] KW_L    = 4'd1;
    localparam logic [3:0] KW_LE   = 4'd2;
    localparam logic [3:0] KW_LET  = 4'd3;
    localparam logic [3:0] KW_P    = 4'd4;
    localparam logic [3:0] KW_PR   = 4'd5;
    localparam logic [3:0] KW_PRI  = 4'd6;
    localparam logic [3:0] KW_PRIN = 4'd7;
    localparam logic [3:0] KW_PRINT = 4'd8;

    typedef enum logic [1:0] {
        RUN_NONE  = 2'd0,
        RUN_NUM   = 2'd1,
        RUN_IDENT = 2'd2,
        RUN_STR   = 2'd3
    } run_kind_t;

    typedef enum logic [3:0] {
        TK_NUMBER  = 4'd0,
        TK_IDENT   = 4'd1,
        TK_STRING  = 4'd2,
        TK_PRINT   = 4'd3,
        TK_EQUALS  = 4'd4,
        TK_PLUS    = 4'd5,
        TK_MINUS   = 4'd6,
        TK_STAR    = 4'd7,
        TK_SLASH   = 4'd8,
        TK_LPAREN  = 4'd9,
        TK_RPAREN  = 4'd10,
        TK_LET     = 4'd11,
        TK_SEMI    = 4'd12,
        TK_ILLEGAL = 4'd13,
        TK_END     = 4'd14
    } token_kind_t;

    typedef struct packed {
        token_kind_t           kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  last;
    } token_t;

    // Up to two tokens produced by one byte, in output order
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } tok_pair_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic [3:0] kw_first(input logic [7:0] c);
        logic [3:0] t;
        t = KW_NONE;
        if (c == CH_LC_L)
            t = KW_L;
        else if (c == CH_LC_P)
            t = KW_P;
        return t;
    endfunction

    function automatic logic [3:0] kw_next(input logic [3:0] t, input logic [7:0] c);
        logic [3:0] n;
        n = KW_NONE;
        case (t)
            KW_L:    n = (c == CH_LC_E) ? KW_LE    : KW_NONE;
            KW_LE:   n = (c == CH_LC_T) ? KW_LET   : KW_NONE;
            KW_P:    n = (c == CH_LC_R) ? KW_PR    : KW_NONE;
            KW_PR:   n = (c == CH_LC_I) ? KW_PRI   : KW_NONE;
            KW_PRI:  n = (c == CH_LC_N) ? KW_PRIN  : KW_NONE;
            KW_PRIN: n = (c == CH_LC_T) ? KW_PRINT : KW_NONE;
            default: n = KW_NONE;
        endcase
        return n;
    endfunction

    // Saturating increment of an offset counter
    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : OFFSET_BITS'(v + 1'b1);
    endfunction

    // Counter value clipped to the 16-bit token field
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [OFFSET_BITS-1:0] v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return (w > WIDE_BITS'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}} : w[FIELD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/script_tokenizer_top.sv
// Top level of the byte-serial script tokenizer.
// Throughput: one byte per cycle while the output is not stalled and each byte
// yields at most one token; a byte that closes a run and emits its own token
// yields two, drained at one per cycle. Tokens are written into a four-entry
// token queue, which sets how far input runs ahead of a stalled output.
// Reset (rst_n low, asynchronous) clears scanner state, offset and the queue.
`default_nettype none

module script_tokenizer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  char_code,
    output logic             token_valid,
    input  wire logic        token_stall,
    output logic [3:0]       token_kind,
    output logic [15:0]      token_start,
    output logic [15:0]      token_length,
    output logic             last_of_run
);

    logic                 accept;
    logic                 full;
    stok_pkg::tok_pair_t  tokens;
    stok_pkg::token_t     head;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    stok_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_code),
        .tokens    (tokens)
    );

    stok_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .tokens     (tokens),
        .full       (full),
        .head_valid (token_valid),
        .pop_stall  (token_stall),
        .head       (head)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_of_run  = head.last;

endmodule

`default_nettype wire

>>> src/stok_scan.sv
// Scanner state and per-byte classification producing up to two tokens.
`default_nettype none

module stok_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          char_code,
    output stok_pkg::tok_pair_t      tokens
);

    stok_pkg::run_kind_t                  run_kind_reg, run_kind_next;
    logic [stok_pkg::OFFSET_BITS-1:0]     run_start_reg, run_start_next;
    logic [stok_pkg::OFFSET_BITS-1:0]     run_length_reg, run_length_next;
    logic [3:0]                           keyword_reg, keyword_next;
    logic [stok_pkg::OFFSET_BITS-1:0]     byte_offset_reg, byte_offset_next;

    logic                  fresh;
    logic                  flush;
    logic                  own_valid;
    stok_pkg::token_kind_t own_kind;
    stok_pkg::token_kind_t flush_kind;
    logic                  own_len_one;
    stok_pkg::token_t      flush_tok;
    stok_pkg::token_t      own_tok;

    // Run continuation, new runs and single-byte tokens
    always_comb
    begin
        run_kind_next    = run_kind_reg;
        run_start_next   = run_start_reg;
        run_length_next  = run_length_reg;
        keyword_next     = keyword_reg;
        fresh            = 1'b1;
        flush            = 1'b0;
        own_valid        = 1'b0;
        own_kind         = stok_pkg::TK_ILLEGAL;
        own_len_one      = 1'b1;

        unique case (run_kind_reg)
            stok_pkg::RUN_STR:
            begin
                if (char_code == stok_pkg::CH_QUOTE)
                begin
                    flush = 1'b1;
                    fresh = 1'b0;
                end
                else if (char_code != stok_pkg::CH_NUL)
                begin
                    run_length_next = stok_pkg::sat_inc(run_length_reg);
                    fresh = 1'b0;
                end
                else
                begin
                    flush = 1'b1;
                end
            end
            stok_pkg::RUN_NUM:
            begin
                if (stok_pkg::is_digit(char_code))
                begin
                    run_length_next = stok_pkg::sat_inc(run_length_reg);
                    fresh = 1'b0;
                end
                else
                begin
                    flush = 1'b1;
                end
            end
            stok_pkg::RUN_IDENT:
            begin
                if (stok_pkg::is_word(char_code))
                begin
                    run_length_next = stok_pkg::sat_inc(run_length_reg);
                    keyword_next = stok_pkg::kw_next(keyword_reg, char_code);
                    fresh = 1'b0;
                end
                else
                begin
                    flush = 1'b1;
                end
            end
            stok_pkg::RUN_NONE:
            begin
            end
        endcase

        if (flush)
        begin
            run_kind_next   = stok_pkg::RUN_NONE;
            run_start_next  = '0;
            run_length_next = '0;
            keyword_next    = stok_pkg::KW_NONE;
        end

        if (fresh)
        begin
            case (char_code) inside
                stok_pkg::CH_SPACE, stok_pkg::CH_TAB, stok_pkg::CH_LF, stok_pkg::CH_CR:
                begin
                end
                stok_pkg::CH_EQUALS: begin own_valid = 1'b1; own_kind = stok_pkg::TK_EQUALS; end
                stok_pkg::CH_PLUS:   begin own_valid = 1'b1; own_kind = stok_pkg::TK_PLUS;   end
                stok_pkg::CH_MINUS:  begin own_valid = 1'b1; own_kind = stok_pkg::TK_MINUS;  end
                stok_pkg::CH_STAR:   begin own_valid = 1'b1; own_kind = stok_pkg::TK_STAR;   end
                stok_pkg::CH_SLASH:  begin own_valid = 1'b1; own_kind = stok_pkg::TK_SLASH;  end
                stok_pkg::CH_LPAREN: begin own_valid = 1'b1; own_kind = stok_pkg::TK_LPAREN; end
                stok_pkg::CH_RPAREN: begin own_valid = 1'b1; own_kind = stok_pkg::TK_RPAREN; end
                stok_pkg::CH_SEMI:   begin own_valid = 1'b1; own_kind = stok_pkg::TK_SEMI;   end
                stok_pkg::CH_QUOTE:
                begin
                    // literal starts after the opening quote
                    run_kind_next   = stok_pkg::RUN_STR;
                    run_start_next  = stok_pkg::sat_inc(byte_offset_reg);
                    run_length_next = '0;
                    keyword_next    = stok_pkg::KW_NONE;
                end
                stok_pkg::CH_NUL:
                begin
                    own_valid   = 1'b1;
                    own_kind    = stok_pkg::TK_END;
                    own_len_one = 1'b0;
                end
                default:
                begin
                    if (stok_pkg::is_digit(char_code))
                    begin
                        run_kind_next   = stok_pkg::RUN_NUM;
                        run_start_next  = byte_offset_reg;
                        run_length_next = stok_pkg::OFFSET_BITS'(1);
                        keyword_next    = stok_pkg::KW_NONE;
                    end
                    else if (stok_pkg::is_word(char_code))
                    begin
                        run_kind_next   = stok_pkg::RUN_IDENT;
                        run_start_next  = byte_offset_reg;
                        run_length_next = stok_pkg::OFFSET_BITS'(1);
                        keyword_next    = stok_pkg::kw_first(char_code);
                    end
                    else
                    begin
                        own_valid = 1'b1;
                        own_kind  = stok_pkg::TK_ILLEGAL;
                    end
                end
            endcase
        end

        // End of input clears everything; otherwise advance the offset
        if (char_code == stok_pkg::CH_NUL)
        begin
            run_kind_next    = stok_pkg::RUN_NONE;
            run_start_next   = '0;
            run_length_next  = '0;
            keyword_next     = stok_pkg::KW_NONE;
            byte_offset_next = '0;
        end
        else
        begin
            byte_offset_next = stok_pkg::sat_inc(byte_offset_reg);
        end
    end

    // Kind of a flushed run
    always_comb
    begin
        case (run_kind_reg)
            stok_pkg::RUN_NUM: flush_kind = stok_pkg::TK_NUMBER;
            stok_pkg::RUN_STR: flush_kind = stok_pkg::TK_STRING;
            default:
            begin
                if (keyword_reg == stok_pkg::KW_LET)
                    flush_kind = stok_pkg::TK_LET;
                else if (keyword_reg == stok_pkg::KW_PRINT)
                    flush_kind = stok_pkg::TK_PRINT;
                else
                    flush_kind = stok_pkg::TK_IDENT;
            end
        endcase
    end

    // Token assembly, flushed run first
    always_comb
    begin
        flush_tok.kind   = flush_kind;
        flush_tok.start  = stok_pkg::to_field(run_start_reg);
        flush_tok.length = stok_pkg::to_field(run_length_reg);
        flush_tok.last   = !own_valid;

        own_tok.kind     = own_kind;
        own_tok.start    = stok_pkg::to_field(byte_offset_reg);
        own_tok.length   = {{(stok_pkg::FIELD_BITS-1){1'b0}}, own_len_one};
        own_tok.last     = 1'b1;

        tokens.count  = 2'({1'b0, flush} + {1'b0, own_valid});
        tokens.first  = flush ? flush_tok : own_tok;
        tokens.second = own_tok;
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg    <= stok_pkg::RUN_NONE;
            run_start_reg   <= '0;
            run_length_reg  <= '0;
            keyword_reg     <= stok_pkg::KW_NONE;
            byte_offset_reg <= '0;
        end
        else if (accept)
        begin
            run_kind_reg    <= run_kind_next;
            run_start_reg   <= run_start_next;
            run_length_reg  <= run_length_next;
            keyword_reg     <= keyword_next;
            byte_offset_reg <= byte_offset_next;
        end
    end

    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (char_code == stok_pkg::CH_NUL)
        |=> (byte_offset_reg == '0) && (run_kind_reg == stok_pkg::RUN_NONE))
        else $error("end of input did not clear scanner state");

    a_idle_run_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (run_kind_reg == stok_pkg::RUN_NONE)
        |-> (run_length_reg == '0) && (keyword_reg == stok_pkg::KW_NONE))
        else $error("no open run but run state not cleared");

    a_kw_only_ident: assert property (@(posedge clk) disable iff (!rst_n)
        (keyword_reg != stok_pkg::KW_NONE) |-> (run_kind_reg == stok_pkg::RUN_IDENT))
        else $error("keyword progress outside an identifier run");

endmodule

`default_nettype wire

>>> src/stok_queue.sv
// Token queue: takes up to two tokens per cycle, delivers one unless stalled.
`default_nettype none

module stok_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire stok_pkg::tok_pair_t tokens,
    output logic                     full,
    output logic                     head_valid,
    input  wire logic                pop_stall,
    output stok_pkg::token_t         head
);

    stok_pkg::token_t                 mem_reg [stok_pkg::QUEUE_DEPTH];
    logic [stok_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [stok_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [stok_pkg::QCNT_BITS-1:0]   count_reg, count_next;
    logic [1:0]                       push_cnt;
    logic                             pop;
    logic [stok_pkg::QPTR_BITS-1:0]   wr_ptr_plus1;

    // Room for two tokens is needed before a byte is taken
    assign full       = (count_reg > stok_pkg::QCNT_BITS'(stok_pkg::QUEUE_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid && !pop_stall;
    assign push_cnt   = push ? tokens.count : 2'd0;
    assign wr_ptr_plus1 = stok_pkg::QPTR_BITS'(wr_ptr_reg + 1'b1);

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = stok_pkg::QPTR_BITS'(wr_ptr_reg + push_cnt);
        rd_ptr_next = pop ? stok_pkg::QPTR_BITS'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = stok_pkg::QCNT_BITS'(count_reg + push_cnt - {1'b0, pop});
    end

    // Token storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
            mem_reg[wr_ptr_reg] <= tokens.first;
        if (push_cnt == 2'd2)
            mem_reg[wr_ptr_plus1] <= tokens.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + push_cnt) <= (stok_pkg::QCNT_BITS+1)'(stok_pkg::QUEUE_DEPTH))
        else $error("token queue overflow");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pop && (push_cnt == 2'd0) |=> $stable(count_reg))
        else $error("queue fill changed without push or pop");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> !tokens.first.last && tokens.second.last)
        else $error("token pair marks wrong final token");

endmodule

`default_nettype wire

>>> test/token_stream_checker.sv
// Predicts the token stream from accepted bytes and checks every token the tokenizer emits.
`default_nettype none

module token_stream_checker
    import stok_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        byte_valid,
    input  wire logic        byte_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        token_valid,
    input  wire logic        token_stall,
    input  wire logic [3:0]  token_kind,
    input  wire logic [15:0] token_start,
    input  wire logic [15:0] token_length,
    input  wire logic        last_of_run,
    output int               mismatch_count,
    output int               tokens_outstanding
);

    // How far an identifier has matched "let" or "print"
    typedef enum logic [3:0] {
        MATCH_NONE,
        MATCH_L,
        MATCH_LE,
        MATCH_LET,
        MATCH_P,
        MATCH_PR,
        MATCH_PRI,
        MATCH_PRIN,
        MATCH_PRINT
    } word_match_t;

    // Scanner state as the block should hold it
    run_kind_t              open_run    = RUN_NONE;
    logic [OFFSET_BITS-1:0] open_start  = '0;
    logic [OFFSET_BITS-1:0] open_length = '0;
    word_match_t            word_match  = MATCH_NONE;
    logic [OFFSET_BITS-1:0] cur_offset  = '0;

    token_t predicted_tokens[$];
    token_t byte_tokens[$];

    initial begin
        mismatch_count     = 0;
        tokens_outstanding = 0;
    end

    function automatic logic [OFFSET_BITS-1:0] bump_sat(input logic [OFFSET_BITS-1:0] v);
        if (&v)
            return v;
        return v + 1'b1;
    endfunction

    function automatic logic [15:0] clip16(input logic [OFFSET_BITS-1:0] v);
        if (OFFSET_BITS > 16 && 64'(v) > 64'hFFFF)
            return 16'hFFFF;
        return 16'(v);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
    endfunction

    function automatic word_match_t match_step(input word_match_t m, input logic [7:0] c);
        case (m)
            MATCH_L:    return (c == CH_LC_E) ? MATCH_LE    : MATCH_NONE;
            MATCH_LE:   return (c == CH_LC_T) ? MATCH_LET   : MATCH_NONE;
            MATCH_P:    return (c == CH_LC_R) ? MATCH_PR    : MATCH_NONE;
            MATCH_PR:   return (c == CH_LC_I) ? MATCH_PRI   : MATCH_NONE;
            MATCH_PRI:  return (c == CH_LC_N) ? MATCH_PRIN  : MATCH_NONE;
            MATCH_PRIN: return (c == CH_LC_T) ? MATCH_PRINT : MATCH_NONE;
            default:    return MATCH_NONE;
        endcase
    endfunction

    task automatic add_token(input token_kind_t kind, input logic [OFFSET_BITS-1:0] start,
                             input logic [OFFSET_BITS-1:0] len);
        token_t t;
        t.kind   = kind;
        t.start  = clip16(start);
        t.length = clip16(len);
        t.last   = 1'b0;
        byte_tokens.push_back(t);
    endtask

    // Emit the open run, if any, and clear the run state
    task automatic close_run();
        token_kind_t k;
        if (open_run != RUN_NONE) begin
            if (open_run == RUN_NUM)
                k = TK_NUMBER;
            else if (open_run == RUN_STR)
                k = TK_STRING;
            else if (word_match == MATCH_LET)
                k = TK_LET;
            else if (word_match == MATCH_PRINT)
                k = TK_PRINT;
            else
                k = TK_IDENT;
            add_token(k, open_start, open_length);
            open_run    = RUN_NONE;
            open_start  = '0;
            open_length = '0;
            word_match  = MATCH_NONE;
        end
    endtask

    // Advance the scanner by one byte and queue the tokens it causes
    task automatic scan_byte(input logic [7:0] c);
        logic   fresh;
        token_t t;
        fresh = 1'b1;
        byte_tokens.delete();

        // continue or close an open run
        case (open_run)
            RUN_STR:
                if (c == CH_QUOTE) begin
                    close_run();
                    fresh = 1'b0;
                end else if (c != CH_NUL) begin
                    open_length = bump_sat(open_length);
                    fresh = 1'b0;
                end else begin
                    close_run();
                end
            RUN_NUM:
                if (digit_char(c)) begin
                    open_length = bump_sat(open_length);
                    fresh = 1'b0;
                end else begin
                    close_run();
                end
            RUN_IDENT:
                if (word_char(c)) begin
                    open_length = bump_sat(open_length);
                    word_match  = match_step(word_match, c);
                    fresh = 1'b0;
                end else begin
                    close_run();
                end
            default: ;
        endcase

        // byte not absorbed by a run: classify it on its own
        if (fresh) begin
            case (c)
                CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
                CH_EQUALS: add_token(TK_EQUALS, cur_offset, OFFSET_BITS'(1));
                CH_PLUS:   add_token(TK_PLUS, cur_offset, OFFSET_BITS'(1));
                CH_MINUS:  add_token(TK_MINUS, cur_offset, OFFSET_BITS'(1));
                CH_STAR:   add_token(TK_STAR, cur_offset, OFFSET_BITS'(1));
                CH_SLASH:  add_token(TK_SLASH, cur_offset, OFFSET_BITS'(1));
                CH_LPAREN: add_token(TK_LPAREN, cur_offset, OFFSET_BITS'(1));
                CH_RPAREN: add_token(TK_RPAREN, cur_offset, OFFSET_BITS'(1));
                CH_SEMI:   add_token(TK_SEMI, cur_offset, OFFSET_BITS'(1));
                CH_QUOTE: begin
                    // string literal starts after the quote
                    open_run    = RUN_STR;
                    open_start  = bump_sat(cur_offset);
                    open_length = '0;
                    word_match  = MATCH_NONE;
                end
                CH_NUL: add_token(TK_END, cur_offset, OFFSET_BITS'(0));
                default:
                    if (digit_char(c)) begin
                        open_run    = RUN_NUM;
                        open_start  = cur_offset;
                        open_length = OFFSET_BITS'(1);
                        word_match  = MATCH_NONE;
                    end else if (word_char(c)) begin
                        open_run    = RUN_IDENT;
                        open_start  = cur_offset;
                        open_length = OFFSET_BITS'(1);
                        word_match  = (c == CH_LC_L) ? MATCH_L :
                                      (c == CH_LC_P) ? MATCH_P : MATCH_NONE;
                    end else begin
                        add_token(TK_ILLEGAL, cur_offset, OFFSET_BITS'(1));
                    end
            endcase
        end

        // end of input restarts the offset; the run is already closed
        if (c == CH_NUL)
            cur_offset = '0;
        else
            cur_offset = bump_sat(cur_offset);

        if (byte_tokens.size() > 0) begin
            t = byte_tokens.pop_back();
            t.last = 1'b1;
            byte_tokens.push_back(t);
        end
        foreach (byte_tokens[i])
            predicted_tokens.push_back(byte_tokens[i]);
    endtask

    task automatic check_token();
        token_t want;
        if (predicted_tokens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected token: kind %0d start %0d length %0d last %0d",
                         token_kind, token_start, token_length, last_of_run);
        end else begin
            want = predicted_tokens.pop_front();
            if (token_kind !== want.kind || token_start !== want.start ||
                token_length !== want.length || last_of_run !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("token mismatch: exp kind %0d start %0d length %0d last %0d,",
                             want.kind, want.start, want.length, want.last,
                             " got kind %0d start %0d length %0d last %0d",
                             token_kind, token_start, token_length, last_of_run);
            end
        end
    endtask

    // Watch both channels at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (byte_valid && !byte_stall)
                scan_byte(char_code);
            if (token_valid && !token_stall)
                check_token();
            tokens_outstanding = predicted_tokens.size();
        end
    end

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench top: drives script bytes into the tokenizer, stalls its output and gives the verdict.
`default_nettype none

module tb;
    import stok_pkg::*;

    typedef enum logic [2:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE,
        STALL_HOLD
    } stall_mode_t;

    localparam int RANDOM_BYTES  = 1650;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 5000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        byte_valid  = 1'b0;
    logic [7:0]  char_code   = 8'h00;
    logic        token_stall = 1'b0;
    logic        byte_stall;
    logic        token_valid;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    int   mismatch_count;
    int   tokens_outstanding;
    logic random_phase = 1'b0;
    int   burst_left   = 0;
    int   bytes_sent   = 0;

    script_tokenizer_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .char_code   (char_code),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_kind  (token_kind),
        .token_start (token_start),
        .token_length(token_length),
        .last_of_run (last_of_run)
    );

    token_stream_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_valid        (byte_valid),
        .byte_stall        (byte_stall),
        .char_code         (char_code),
        .token_valid       (token_valid),
        .token_stall       (token_stall),
        .token_kind        (token_kind),
        .token_start       (token_start),
        .token_length      (token_length),
        .last_of_run       (last_of_run),
        .mismatch_count    (mismatch_count),
        .tokens_outstanding(tokens_outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop
    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // Receiver stall pattern, with one long hold-off once random traffic runs
    initial
    begin
        stall_mode_t mode;
        int          seg_left;
        logic        held_off;
        mode     = STALL_NONE;
        seg_left = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (seg_left == 0) begin
                mode     = stall_mode_t'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 150);
                if (random_phase && !held_off) begin
                    held_off = 1'b1;
                    mode     = STALL_HOLD;
                    seg_left = HOLD_CYCLES;
                end
            end
            seg_left--;
            case (mode)
                STALL_NONE:   token_stall <= 1'b0;
                STALL_LIGHT:  token_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  token_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: token_stall <= ~token_stall;
                default:      token_stall <= 1'b1;
            endcase
        end
    end

    // Offer one byte in bursts with random gaps; called and returns at a falling edge
    task automatic offer_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                byte_valid <= 1'b0;
                char_code  <= 8'($urandom);
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        bytes_sent++;
        byte_valid <= 1'b1;
        char_code  <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            offer_byte(s[i]);
    endtask

    function automatic logic [7:0] word_byte();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'(8'h41 + r);
        if (r < 52)
            return 8'(8'h61 + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] digit_byte();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] space_byte();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // One lexical piece of script, mostly well formed, sometimes noise
    task automatic offer_fragment();
        int         n;
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1: begin
                offer_byte(word_byte());
                n = $urandom_range(0, 6);
                repeat (n)
                    offer_byte(($urandom_range(0, 3) == 0) ? digit_byte() : word_byte());
            end
            2, 3: begin
                case ($urandom_range(0, 9))
                    0:       send_text("let");
                    1:       send_text("print");
                    2:       send_text("le");
                    3:       send_text("lets");
                    4:       send_text("prin");
                    5:       send_text("printx");
                    6:       send_text("p");
                    7:       send_text("Let");
                    8:       send_text("l_et");
                    default: send_text("xprint");
                endcase
            end
            4, 5: begin
                n = $urandom_range(1, 6);
                repeat (n)
                    offer_byte(digit_byte());
            end
            6: begin
                // string with arbitrary content, sometimes left open
                offer_byte(CH_QUOTE);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    b = 8'($urandom_range(1, 255));
                    offer_byte((b == CH_QUOTE) ? CH_SPACE : b);
                end
                if ($urandom_range(0, 7) != 0)
                    offer_byte(CH_QUOTE);
            end
            7, 8: begin
                case ($urandom_range(0, 7))
                    0:       b = CH_EQUALS;
                    1:       b = CH_PLUS;
                    2:       b = CH_MINUS;
                    3:       b = CH_STAR;
                    4:       b = CH_SLASH;
                    5:       b = CH_LPAREN;
                    6:       b = CH_RPAREN;
                    default: b = CH_SEMI;
                endcase
                offer_byte(b);
            end
            9:  offer_byte(space_byte());
            10: offer_byte(8'($urandom_range(0, 255)));
            default:
                if ($urandom_range(0, 1) == 0)
                    offer_byte(CH_NUL);
                else
                    offer_byte(8'($urandom_range(128, 255)));
        endcase
        if ($urandom_range(0, 1) == 0)
            offer_byte(space_byte());
    endtask

    // Main stimulus and verdict
    initial
    begin
        int wait_count;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every token kind but numbers, whitespace, keywords, empty and open strings
        offer_byte(CH_NUL);
        send_text("print\"\";let(x_9)+-*/= \t\n\r");
        offer_byte(8'hFF);
        send_text("\"ab");
        offer_byte(CH_NUL);

        // random scripts
        random_phase = 1'b1;
        bytes_sent   = 0;
        while (bytes_sent < RANDOM_BYTES)
            offer_fragment();

        // short closing script after a fresh start
        offer_byte(CH_NUL);
        send_text(";\"x\"a");
        offer_byte(CH_NUL);

        // drain
        byte_valid <= 1'b0;
        wait_count = 0;
        while (tokens_outstanding != 0 && wait_count < DRAIN_LIMIT) begin
            @(negedge clk);
            wait_count++;
        end
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && tokens_outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
